// ===== hdl/imd_pkg.sv =====
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants for the IMD disk image decoder.
// ----------------------------------------------------------------------------
package imd_pkg;

    // Fixed format constants
    localparam logic [7:0] COMMENT_END       = 8'h1A;
    localparam logic [7:0] MAX_MODE          = 8'd5;
    localparam logic [7:0] MAX_HEAD          = 8'd1;
    localparam logic [7:0] MAX_TYPE          = 8'd8;
    localparam int         SIZE_BASE_LOG     = 7;     // sector size is 128 << code
    localparam logic [7:0] RESET_MAX_CYL     = 8'd80;
    localparam logic [2:0] RESET_MAX_CODE    = 3'd6;

    // Configuration register indexes
    typedef enum logic {
        CFG_MAX_CYLINDER  = 1'b0,
        CFG_MAX_SIZE_CODE = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NO_HEADER   = 4'd1,
        ST_BAD_MODE    = 4'd2,
        ST_BAD_CYL     = 4'd3,
        ST_BAD_HEAD    = 4'd4,
        ST_BAD_COUNT   = 4'd5,
        ST_BAD_SIZE    = 4'd6,
        ST_BAD_TYPE    = 4'd7,
        ST_BAD_MAP     = 4'd8,
        ST_TRUNCATED   = 4'd9,
        ST_NO_TRACKS   = 4'd10,
        ST_OVERFLOW    = 4'd11
    } status_t;

    typedef enum logic [10:0] {
        PH_COMMENT = 11'b000_0000_0001,
        PH_MODE    = 11'b000_0000_0010,
        PH_CYL     = 11'b000_0000_0100,
        PH_HEAD    = 11'b000_0000_1000,
        PH_COUNT   = 11'b000_0001_0000,
        PH_SIZE    = 11'b000_0010_0000,
        PH_MAP     = 11'b000_0100_0000,
        PH_TYPE    = 11'b000_1000_0000,
        PH_DATA    = 11'b001_0000_0000,
        PH_FILL    = 11'b010_0000_0000,
        PH_DONE    = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [31:0] image_address;
        logic [7:0]  fill_value;
        logic [13:0] run_length;
        logic        finished;
        status_t     status;
    } result_t;

endpackage

// ===== hdl/imd_out_buf.sv =====
// ----------------------------------------------------------------------------
// imd_out_buf
// Two-entry result buffer: output register plus skid register, so the
// decoder keeps taking bytes while a result waits downstream.
// ----------------------------------------------------------------------------
module imd_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  imd_pkg::result_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output imd_pkg::result_t pop_data
);
    import imd_pkg::*;

    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_reg;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (head_valid_reg && pop_ready)
        begin
            head_valid_next = 1'b0;
        end
        if (!head_valid_next && skid_valid_reg)
        begin
            head_next       = skid_reg;
            head_valid_next = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (push_valid && push_ready)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // skid only fills behind a held head entry
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry without head entry");

endmodule

// ===== hdl/imd_disk_image_decoder.sv =====
// ----------------------------------------------------------------------------
// imd_disk_image_decoder
// Parses an IMD image byte stream and emits write commands (address, value,
// run length) that lay each sector out in a flat logical disk image.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | sink      | in_valid / in_ready   | file_byte, end_of_file
//  cfg      | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//  out      | source    | out_valid / out_ready | image_address, fill_value,
//           |           |                       | run_length, finished, status
//
//  One byte per cycle while in_ready is high; each byte is decoded in the cycle it
//  is taken and its result lands in a two-entry output buffer in the next cycle.
//  The sector map is a RAM whose read register is prefetched each cycle with
//  the entry for the next sector position, so a data byte never waits on it.
//  in_ready drops only while both output buffer entries are full.
//  Reset clears control state at once; no clearing pass. cfg is always ready.
// ----------------------------------------------------------------------------
module imd_disk_image_decoder #(
    parameter int MAX_SECTORS      = 256,
    parameter int MAX_SECTOR_BYTES = 8192,
    parameter int ADDRESS_BITS     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] image_address,
    output logic [7:0]  fill_value,
    output logic [13:0] run_length,
    output logic        finished,
    output logic [3:0]  status
);
    import imd_pkg::*;

    localparam int IDX_W     = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_W     = $clog2(MAX_SECTORS + 1);
    localparam int LOG_BYTES = $clog2(MAX_SECTOR_BYTES + 1) - 1;
    localparam int MAX_CODE  = LOG_BYTES - SIZE_BASE_LOG;
    localparam int SB_W      = LOG_BYTES + 1;
    localparam int SPAN_W    = CNT_W + LOG_BYTES;
    localparam int BASE_W    = ADDRESS_BITS + 1;
    localparam int SUM_W     = ((BASE_W > SPAN_W) ? BASE_W : SPAN_W) + 1;
    localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDRESS_BITS;

    // parser state
    phase_t              phase_reg;
    phase_t              phase_next;
    logic                comment_seen_reg;
    logic                comment_seen_next;
    logic                any_done_reg;
    logic                any_done_next;
    logic [BASE_W-1:0]   base_reg;
    logic [BASE_W-1:0]   base_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [2:0]          code_reg;
    logic [2:0]          code_next;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;
    logic [SB_W-1:0]     off_reg;
    logic [SB_W-1:0]     off_next;
    logic [7:0]          max_cyl_reg;
    logic [2:0]          max_code_reg;
    logic [MAX_SECTORS-1:0] used_reg;

    // sector map RAM
    logic [IDX_W-1:0]    map_mem [MAX_SECTORS];
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                map_write;
    logic                map_we;
    logic                used_clear;

    logic                accept;
    logic                live;
    logic                wr;
    logic                finish_ok;
    status_t             err;
    logic [7:0]          wr_value;
    logic [13:0]         wr_run;

    logic [SB_W-1:0]     sector_bytes;
    logic [SPAN_W-1:0]   track_bytes;
    logic [SPAN_W-1:0]   track_bytes_new;
    logic [SPAN_W-1:0]   slot_span;
    logic [SUM_W-1:0]    write_sum;
    logic [SUM_W-1:0]    end_sum;
    logic [SUM_W-1:0]    new_sum;
    logic [CNT_W-1:0]    pos_inc;
    logic                pos_last;
    logic [SB_W-1:0]     off_inc;
    logic [IDX_W-1:0]    map_idx;
    logic                map_in_range;
    logic [31:0]         wr_addr;

    logic                push_valid;
    logic                push_ready;
    result_t             push_data;
    result_t             pop_data;

    assign accept    = in_valid && in_ready;
    assign in_ready  = push_ready;
    assign cfg_ready = 1'b1;

    // datapath shared by all phases
    assign sector_bytes    = (SB_W'(1) << code_reg) << SIZE_BASE_LOG;
    assign track_bytes     = (SPAN_W'(count_reg) << code_reg) << SIZE_BASE_LOG;
    assign track_bytes_new = (SPAN_W'(count_reg) << file_byte[2:0]) << SIZE_BASE_LOG;
    assign slot_span       = ((SPAN_W'(slot_reg) << code_reg) << SIZE_BASE_LOG)
                             + SPAN_W'(off_reg);
    assign write_sum       = SUM_W'(base_reg) + SUM_W'(slot_span);
    assign end_sum         = SUM_W'(base_reg) + SUM_W'(track_bytes);
    assign new_sum         = SUM_W'(base_reg) + SUM_W'(track_bytes_new);
    assign wr_addr         = 32'(write_sum[ADDRESS_BITS-1:0]);
    assign pos_inc         = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_last        = pos_inc >= count_reg;
    assign off_inc         = off_reg + SB_W'(1);
    assign map_idx         = IDX_W'(file_byte - 8'd1);
    assign map_in_range    = (file_byte != 8'd0) && (9'(file_byte) <= 9'(count_reg));

    always_comb
    begin
        phase_next        = phase_reg;
        comment_seen_next = comment_seen_reg;
        any_done_next     = any_done_reg;
        base_next         = base_reg;
        count_next        = count_reg;
        code_next         = code_reg;
        pos_next          = pos_reg;
        off_next          = off_reg;
        live              = 1'b1;
        wr                = 1'b0;
        wr_value          = 8'd0;
        wr_run            = 14'd0;
        err               = ST_OK;
        finish_ok         = 1'b0;
        map_write         = 1'b0;
        used_clear        = 1'b0;

        case (phase_reg)
            PH_COMMENT:
            begin
                if (file_byte == COMMENT_END)
                begin
                    if (!comment_seen_reg)
                        err = ST_NO_HEADER;
                    else
                        phase_next = PH_MODE;
                end
                else
                begin
                    comment_seen_next = 1'b1;
                end
            end
            PH_MODE:
            begin
                if (file_byte > MAX_MODE)
                    err = ST_BAD_MODE;
                else
                    phase_next = PH_CYL;
            end
            PH_CYL:
            begin
                if (file_byte > max_cyl_reg)
                    err = ST_BAD_CYL;
                else
                    phase_next = PH_HEAD;
            end
            PH_HEAD:
            begin
                if (file_byte > MAX_HEAD)
                    err = ST_BAD_HEAD;
                else
                    phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                if (file_byte == 8'd0 || 9'(file_byte) > 9'(MAX_SECTORS))
                begin
                    err = ST_BAD_COUNT;
                end
                else
                begin
                    count_next = CNT_W'(file_byte);
                    used_clear = 1'b1;
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (file_byte > 8'(max_code_reg) || file_byte > 8'(MAX_CODE))
                begin
                    err = ST_BAD_SIZE;
                end
                else if (new_sum > ADDR_LIMIT)
                begin
                    err = ST_OVERFLOW;
                end
                else
                begin
                    code_next  = file_byte[2:0];
                    pos_next   = '0;
                    off_next   = '0;
                    phase_next = PH_MAP;
                end
            end
            PH_MAP:
            begin
                if (!map_in_range)
                begin
                    err = ST_BAD_MAP;
                end
                else if (used_reg[map_idx])
                begin
                    err = ST_BAD_MAP;
                end
                else
                begin
                    map_write = 1'b1;
                    if (pos_last)
                    begin
                        pos_next   = '0;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        pos_next = IDX_W'(pos_inc);
                    end
                end
            end
            PH_TYPE:
            begin
                if (file_byte > MAX_TYPE)
                begin
                    err = ST_BAD_TYPE;
                end
                else if (file_byte[0])
                begin
                    off_next   = '0;
                    phase_next = PH_DATA;
                end
                else if (file_byte == 8'd0)
                begin
                    off_next = '0;
                    wr       = 1'b1;
                    wr_run   = 14'(sector_bytes);
                end
                else
                begin
                    phase_next = PH_FILL;
                end
            end
            PH_DATA:
            begin
                wr       = 1'b1;
                wr_value = file_byte;
                wr_run   = 14'd1;
                off_next = off_inc;
                if (off_inc >= sector_bytes)
                    off_next = '0;
            end
            PH_FILL:
            begin
                off_next = '0;
                wr       = 1'b1;
                wr_value = file_byte;
                wr_run   = 14'(sector_bytes);
            end
            PH_DONE:
            begin
                live = 1'b0;
            end
            default:
            begin
                live       = 1'b0;
                phase_next = PH_DONE;
            end
        endcase

        // end of a sector: zero fill, byte fill, or the last data byte
        if (err == ST_OK && ((phase_reg == PH_TYPE && file_byte == 8'd0)
                             || phase_reg == PH_FILL
                             || (phase_reg == PH_DATA && off_inc >= sector_bytes)))
        begin
            if (pos_last)
            begin
                base_next     = BASE_W'(end_sum);
                any_done_next = 1'b1;
                pos_next      = '0;
                phase_next    = PH_MODE;
            end
            else
            begin
                pos_next   = IDX_W'(pos_inc);
                phase_next = PH_TYPE;
            end
        end

        if (live && err == ST_OK && end_of_file)
        begin
            case (phase_next)
                PH_COMMENT:
                    err = comment_seen_next ? ST_NO_TRACKS : ST_NO_HEADER;
                PH_MODE:
                begin
                    if (any_done_next)
                        finish_ok = 1'b1;
                    else
                        err = ST_NO_TRACKS;
                end
                default:
                    err = ST_TRUNCATED;
            endcase
        end

        if (err != ST_OK || finish_ok)
            phase_next = PH_DONE;
    end

    always_comb
    begin
        push_data.image_address = wr_addr;
        push_data.fill_value    = wr_value;
        push_data.run_length    = wr_run;
        push_data.finished      = finish_ok;
        push_data.status        = ST_OK;
        if (err != ST_OK)
        begin
            push_data.image_address = 32'd0;
            push_data.fill_value    = 8'd0;
            push_data.run_length    = 14'd0;
            push_data.finished      = 1'b1;
            push_data.status        = err;
        end
        else if (!wr)
        begin
            push_data.image_address = 32'd0;
        end
    end

    assign push_valid = accept && live && (err != ST_OK || finish_ok || wr);
    assign map_we     = accept && map_write;

    // prefetch the slot for the position the parser will hold next cycle
    assign rd_addr = accept ? pos_next : pos_reg;

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[pos_reg] <= map_idx;
        if (map_we && pos_reg == rd_addr)
            slot_reg <= map_idx;
        else
            slot_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COMMENT;
            comment_seen_reg <= 1'b0;
            any_done_reg     <= 1'b0;
            base_reg         <= '0;
            count_reg        <= '0;
            code_reg         <= '0;
            pos_reg          <= '0;
            off_reg          <= '0;
            used_reg         <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            comment_seen_reg <= comment_seen_next;
            any_done_reg     <= any_done_next;
            base_reg         <= base_next;
            count_reg        <= count_next;
            code_reg         <= code_next;
            pos_reg          <= pos_next;
            off_reg          <= off_next;
            if (used_clear)
                used_reg <= '0;
            else if (map_write)
                used_reg[map_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cyl_reg  <= RESET_MAX_CYL;
            max_code_reg <= RESET_MAX_CODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_CYLINDER:  max_cyl_reg  <= cfg_data;
                CFG_MAX_SIZE_CODE: max_code_reg <= cfg_data[2:0];
                default:           max_cyl_reg  <= max_cyl_reg;
            endcase
        end
    end

    imd_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (pop_data)
    );

    assign image_address = pop_data.image_address;
    assign fill_value    = pop_data.fill_value;
    assign run_length    = pop_data.run_length;
    assign finished      = pop_data.finished;
    assign status        = pop_data.status;

    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_data.finished) |=> phase_reg == PH_DONE)
        else $error("parser still live after final transaction");

    a_pos_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MAP || phase_reg == PH_TYPE || phase_reg == PH_DATA
         || phase_reg == PH_FILL) |-> CNT_W'(pos_reg) < count_reg)
        else $error("sector position beyond sector count");

    a_off_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> off_reg < sector_bytes)
        else $error("byte offset beyond sector size");

    a_silent_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DONE) |-> !push_valid)
        else $error("result after final transaction");

endmodule
